// ===== src/e2cd_pkg.sv =====
// shared types, constants and calendar helpers for the epoch to calendar date block
package e2cd_pkg;

    localparam logic [11:0] EPOCH_YEAR          = 12'd1970;
    localparam logic [11:0] COMMON_CENTURY_YEAR = 12'd2100;
    // seconds / 86400 is (seconds >> 7) / 675, done by reciprocal with a shift of 35
    localparam logic [25:0] DAY_RECIP           = 26'd50903317;
    localparam logic [9:0]  DAY_ODD_FACTOR      = 10'd675;
    // days / 7 by reciprocal with a shift of 19
    localparam logic [16:0] WEEK_RECIP          = 17'd74899;
    localparam logic [16:0] SECONDS_PER_HOUR    = 17'd3600;
    localparam logic [16:0] SECONDS_PER_MINUTE  = 17'd60;
    localparam logic [3:0]  DAYS_PER_WEEK       = 4'd7;
    localparam logic [3:0]  EPOCH_WEEKDAY       = 4'd4;
    localparam logic [3:0]  LAST_MONTH          = 4'd12;

    typedef struct packed {
        logic load;
        logic day_mul;
        logic day_split;
        logic wk_mul;
        logic wk_split;
        logic year_step;
        logic month_step;
        logic hour_step;
        logic min_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
        logic hour_fit;
        logic min_fit;
    } sts_t;

    function automatic logic [4:0] month_length(input logic [3:0] mon, input logic leap);
        logic [4:0] n;
        case (mon) inside
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            4'd2:                    n = leap ? 5'd29 : 5'd28;
            default:                 n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

// ===== src/epoch_to_calendar_date_top.sv =====
// top level of the unix time to utc calendar date converter
// done rises after the reciprocal divide (day multiply, day split, week multiply and
//   week split), then the year, month, hour and minute loops stepped one unit at a time
// one request at a time; busy is low while done is high
// result stays on the output ports until the next one; done is high for a single cycle
// reset: rst_n asynchronous active low, returns to idle with done low
module epoch_to_calendar_date_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] epoch_seconds,
    output logic        done,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [2:0]  weekday
);
    import e2cd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    e2cd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    e2cd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .epoch_seconds (epoch_seconds),
        .sts           (sts),
        .done          (done),
        .year          (year),
        .month         (month),
        .day_of_month  (day_of_month),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .weekday       (weekday)
    );

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result issued while a request is still in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
                  && weekday <= 3'd6))
        else $error("calendar date out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
        else $error("time of day out of range");
`endif

endmodule

// ===== src/e2cd_ctrl.sv =====
// sequencing state machine for the epoch to calendar date block
module e2cd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  e2cd_pkg::sts_t sts,
    output e2cd_pkg::cmd_t cmd,
    output logic          busy
);
    import e2cd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_YEAR  = 3'd2;
    localparam logic [2:0] S_MONTH = 3'd3;
    localparam logic [2:0] S_HOUR  = 3'd4;
    localparam logic [2:0] S_MIN   = 3'd5;

    localparam logic [1:0] STEP_DAY_MUL   = 2'd0;
    localparam logic [1:0] STEP_DAY_SPLIT = 2'd1;
    localparam logic [1:0] STEP_WK_MUL    = 2'd2;
    localparam logic [1:0] STEP_WK_SPLIT  = 2'd3;

    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = STEP_DAY_MUL;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                case (cnt_reg)
                    STEP_DAY_MUL:   cmd.day_mul   = 1'b1;
                    STEP_DAY_SPLIT: cmd.day_split = 1'b1;
                    STEP_WK_MUL:    cmd.wk_mul    = 1'b1;
                    default:        cmd.wk_split  = 1'b1;
                endcase
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == STEP_WK_SPLIT)
                    state_next = S_YEAR;
            end
            S_YEAR:
            begin
                if (sts.year_fit)
                    state_next = S_MONTH;
                else
                    cmd.year_step = 1'b1;
            end
            S_MONTH:
            begin
                if (sts.month_fit)
                    state_next = S_HOUR;
                else
                    cmd.month_step = 1'b1;
            end
            S_HOUR:
            begin
                if (sts.hour_fit)
                    state_next = S_MIN;
                else
                    cmd.hour_step = 1'b1;
            end
            S_MIN:
            begin
                if (sts.min_fit)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    cmd.min_step = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== src/e2cd_datapath.sv =====
// divider, calendar counters and result registers for the epoch to calendar date block
module e2cd_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  e2cd_pkg::cmd_t cmd,
    input  logic [31:0]    epoch_seconds,
    output e2cd_pkg::sts_t sts,
    output logic           done,
    output logic [11:0]    year,
    output logic [3:0]     month,
    output logic [4:0]     day_of_month,
    output logic [4:0]     hour,
    output logic [5:0]     minute,
    output logic [5:0]     second,
    output logic [2:0]     weekday
);
    import e2cd_pkg::*;

    // num_reg holds the dividend, then the quotient, then the days left
    logic [31:0] num_reg, num_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] prod_reg, prod_next;
    logic [2:0]  qmod_reg, qmod_next;
    logic [11:0] yr_reg, yr_next;
    logic [3:0]  mon_reg, mon_next;
    logic [4:0]  hr_reg, hr_next;
    logic [5:0]  min_reg, min_next;
    logic        done_reg;

    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  dom_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [2:0]  weekday_reg;

    logic [50:0] day_prod;
    logic [32:0] week_prod;
    logic [25:0] day_back;
    logic [9:0]  sod_hi;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [3:0]  wk_sum;
    logic [2:0]  wk_val;

    assign day_prod  = 51'(num_reg[31:7]) * 51'(DAY_RECIP);
    assign week_prod = 33'(num_reg[15:0]) * 33'(WEEK_RECIP);
    assign day_back  = 26'(prod_reg) * 26'(DAY_ODD_FACTOR);
    assign sod_hi    = 10'(26'(num_reg[31:7]) - day_back);
    assign leap      = (yr_reg[1:0] == 2'b00) && (yr_reg != COMMON_CENTURY_YEAR);
    assign ylen      = leap ? 9'd366 : 9'd365;
    assign mlen      = month_length(mon_reg, leap);
    assign wk_sum    = {1'b0, qmod_reg} + EPOCH_WEEKDAY;
    assign wk_val    = (wk_sum >= DAYS_PER_WEEK) ? 3'(wk_sum - DAYS_PER_WEEK) : wk_sum[2:0];

    assign sts.year_fit  = (num_reg[15:0] < {7'd0, ylen});
    assign sts.month_fit = (mon_reg == LAST_MONTH) || (num_reg[15:0] < {11'd0, mlen});
    assign sts.hour_fit  = (rem_reg < SECONDS_PER_HOUR);
    assign sts.min_fit   = (rem_reg < SECONDS_PER_MINUTE);

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        prod_next = prod_reg;
        qmod_next = qmod_reg;
        yr_next   = yr_reg;
        mon_next  = mon_reg;
        hr_next   = hr_reg;
        min_next  = min_reg;
        if (cmd.load)
        begin
            num_next  = epoch_seconds;
            rem_next  = '0;
            qmod_next = '0;
            yr_next   = EPOCH_YEAR;
            mon_next  = 4'd1;
            hr_next   = '0;
            min_next  = '0;
        end
        else if (cmd.day_mul)
        begin
            prod_next = day_prod[50:35];
        end
        else if (cmd.day_split)
        begin
            num_next = {16'd0, prod_reg};
            rem_next = {sod_hi, num_reg[6:0]};
        end
        else if (cmd.wk_mul)
        begin
            prod_next = {2'd0, week_prod[32:19]};
        end
        else if (cmd.wk_split)
        begin
            // days - 7 * (days / 7) taken mod 8
            qmod_next = 3'(num_reg[2:0] + prod_reg[2:0]);
        end
        else if (cmd.year_step)
        begin
            num_next = {16'd0, num_reg[15:0] - {7'd0, ylen}};
            yr_next  = yr_reg + 12'd1;
        end
        else if (cmd.month_step)
        begin
            num_next = {16'd0, num_reg[15:0] - {11'd0, mlen}};
            mon_next = mon_reg + 4'd1;
        end
        else if (cmd.hour_step)
        begin
            rem_next = rem_reg - SECONDS_PER_HOUR;
            hr_next  = hr_reg + 5'd1;
        end
        else if (cmd.min_step)
        begin
            rem_next = rem_reg - SECONDS_PER_MINUTE;
            min_next = min_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        prod_reg <= prod_next;
        qmod_reg <= qmod_next;
        yr_reg   <= yr_next;
        mon_reg  <= mon_next;
        hr_reg   <= hr_next;
        min_reg  <= min_next;
        if (cmd.finish)
        begin
            year_reg    <= yr_reg;
            month_reg   <= mon_reg;
            dom_reg     <= num_reg[4:0] + 5'd1;
            hour_reg    <= hr_reg;
            minute_reg  <= min_reg;
            second_reg  <= rem_reg[5:0];
            weekday_reg <= wk_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish;
    end

    assign done         = done_reg;
    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = dom_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign weekday      = weekday_reg;

endmodule

// ===== bench/epoch_to_calendar_date_top_test.sv =====
// self-checking testbench for the unix time to utc calendar date converter
`timescale 1ns / 1ps

module epoch_to_calendar_date_top_test;

    localparam int unsigned DAY_SECONDS    = 86400;
    localparam int unsigned HOUR_SECONDS   = 3600;
    localparam int unsigned MINUTE_SECONDS = 60;
    localparam int unsigned FIRST_YEAR     = 1970;
    localparam int unsigned LAST_FULL_DAY  = 49709;
    localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned WEEKDAY_OFS [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    localparam int          RANDOM_ITEMS   = 1800;
    localparam int          MAX_GAP        = 40;
    localparam int          DRAIN_CYCLES   = 300;
    localparam int          STALL_LIMIT    = 5000;
    localparam int          REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } civil_date_t;

    class date_scoreboard;
        civil_date_t pending_dates[$];
        int          mismatches;
        int          requests;
        int          results;
        int unsigned min_year;
        int unsigned max_year;

        function new();
            mismatches = 0;
            requests   = 0;
            results    = 0;
            min_year   = 4095;
            max_year   = 0;
        endfunction

        function bit is_leap(int unsigned yr);
            return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        endfunction

        function civil_date_t civil_from_epoch(logic [31:0] t);
            int unsigned days;
            int unsigned sod;
            int unsigned yr;
            int unsigned mon;
            int unsigned span;
            int unsigned y;
            civil_date_t d;
            days = t / DAY_SECONDS;
            sod  = t % DAY_SECONDS;
            yr   = FIRST_YEAR;
            mon  = 1;
            forever
            begin
                span = is_leap(yr) ? 366 : 365;
                if (days < span)
                    break;
                days -= span;
                yr++;
            end
            while (mon < 12)
            begin
                span = MONTH_LEN[mon - 1] + ((mon == 2 && is_leap(yr)) ? 1 : 0);
                if (days < span)
                    break;
                days -= span;
                mon++;
            end
            y = (mon < 3) ? yr - 1 : yr;
            d.year         = 12'(yr);
            d.month        = 4'(mon);
            d.day_of_month = 5'(days + 1);
            d.hour         = 5'(sod / HOUR_SECONDS);
            d.minute       = 6'((sod / MINUTE_SECONDS) % 60);
            d.second       = 6'(sod % MINUTE_SECONDS);
            d.weekday      = 3'((y + y / 4 - y / 100 + y / 400 + WEEKDAY_OFS[mon - 1]
                                 + days + 1) % 7);
            return d;
        endfunction

        function void note_request(logic [31:0] t);
            civil_date_t d;
            d = civil_from_epoch(t);
            pending_dates.push_back(d);
            requests++;
            if (d.year < min_year)
                min_year = d.year;
            if (d.year > max_year)
                max_year = d.year;
        endfunction

        function void check_result(civil_date_t got);
            civil_date_t want;
            results++;
            if (pending_dates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result with no request pending: %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                             got.year, got.month, got.day_of_month, got.hour, got.minute,
                             got.second, got.weekday);
                return;
            end
            want = pending_dates.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d wd %0d,",
                             want.year, want.month, want.day_of_month, want.hour,
                             want.minute, want.second, want.weekday,
                             " got %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                             got.year, got.month, got.day_of_month, got.hour,
                             got.minute, got.second, got.weekday);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] epoch_seconds;
    logic        done;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;

    date_scoreboard sb;
    int             stall_cycles;

    epoch_to_calendar_date_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .epoch_seconds (epoch_seconds),
        .done          (done),
        .year          (year),
        .month         (month),
        .day_of_month  (day_of_month),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .weekday       (weekday)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(epoch_seconds);
            if (done)
                sb.check_result({year, month, day_of_month, hour, minute, second, weekday});
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || done))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_request(input logic [31:0] value, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        epoch_seconds <= value;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [31:0] random_epoch();
        int unsigned day;
        logic [31:0] value;
        case ($urandom_range(9))
            6:
            begin
                day   = $urandom_range(LAST_FULL_DAY);
                value = day * DAY_SECONDS + ($urandom_range(1) ? DAY_SECONDS - 1 : 0);
            end
            7:       value = $urandom_range(32'hFFFF_FFFF, 32'hFFF0_0000);
            8:       value = $urandom_range(200000);
            default: value = $urandom();
        endcase
        return value;
    endfunction

    initial
    begin
        logic [31:0] directed [$];
        int          idle_pct;
        sb            = new();
        stall_cycles  = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        epoch_seconds = '0;
        directed = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                     32'd94607999, 32'd94608000, 32'd946684799, 32'd946684800,
                     32'd951782400, 32'd951868799, 32'd951868800, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'd4107542399, 32'd4107542400, 32'd4291747199,
                     32'd4291747200, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE,
                     32'hFFFF_FFFF};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles now and then, but the last third of the random requests has no idle gaps
        foreach (directed[i])
            send_request(directed[i], 24);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i < RANDOM_ITEMS / 3)
                idle_pct = 24;
            else if (i < 2 * RANDOM_ITEMS / 3)
                idle_pct = 80;
            else
                idle_pct = 0;
            send_request(random_epoch(), idle_pct);
        end
        start <= 1'b0;

        while (sb.pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests converted, %0d results checked, years %0d to %0d covered",
                 sb.requests, sb.results, sb.min_year, sb.max_year);
        $display("leap days, century non-leap year 2100, month ends and top of range included");
        if (sb.mismatches == 0 && sb.pending_dates.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
src/e2cd_pkg.sv
src/e2cd_ctrl.sv
src/e2cd_datapath.sv
src/epoch_to_calendar_date_top.sv
bench/epoch_to_calendar_date_top_test.sv
